### design/crr_pkg.sv
`timescale 1ns / 1ps
package crr_pkg;
	localparam int MAX_CUBOIDS_DEF = 4;
	localparam int STORE_DEPTH_DEF = 4096;
	localparam int COORD_BITS_DEF = 10;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [1:0] MODE_COPY = 2'd0;
	localparam logic [1:0] MODE_SQSUM = 2'd1;
	localparam logic [1:0] MODE_MAX = 2'd2;
	localparam logic [1:0] MODE_MIN = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_ADDR = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic        valid;
		logic [11:0] echo;
		logic [1:0]  status;
		logic [63:0] value;
	} crr_result_t;
endpackage

### design/crr_store.sv
`timescale 1ns / 1ps
module crr_store #(
	parameter int STORE_DEPTH = crr_pkg::STORE_DEPTH_DEF,
	parameter int AW = $clog2(STORE_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/crr_ctrl.sv
`timescale 1ns / 1ps
module crr_ctrl #(
	parameter int MAX_CUBOIDS = crr_pkg::MAX_CUBOIDS_DEF,
	parameter int STORE_DEPTH = crr_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS = crr_pkg::COORD_BITS_DEF,
	parameter int AW = $clog2(STORE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [9:0]           x,
	input  logic [9:0]           y,
	input  logic [9:0]           z,
	input  logic [9:0]           x_end,
	input  logic [9:0]           y_end,
	input  logic [9:0]           z_end,
	input  logic [1:0]           cuboid,
	input  logic [11:0]          entry,
	input  logic [31:0]          sample,
	input  logic [63:0]          init_value,
	input  logic [1:0]           mode,
	input  logic [2:0]           count,
	output logic                 res_valid,
	input  logic                 res_take,
	output crr_pkg::crr_result_t res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [63:0]          mem_wdata,
	output logic [AW-1:0]        mem_raddr,
	input  logic [63:0]          mem_rdata
);
	localparam int SW = (MAX_CUBOIDS > 1) ? $clog2(MAX_CUBOIDS) : 1;
	localparam int CW = COORD_BITS;
	localparam int VW = AW + 2;
	localparam int PW = 3 * CW + 2;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_WB = 3'd3;
	localparam logic [2:0] S_LD1 = 3'd4;
	localparam logic [2:0] S_LD2 = 3'd5;
	localparam logic [2:0] S_RDO = 3'd6;
	localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};

	logic [CW-1:0] lo_q [MAX_CUBOIDS][3];
	logic [CW-1:0] hi_q [MAX_CUBOIDS][3];
	logic [VW-1:0] base_q [MAX_CUBOIDS];
	logic [VW-1:0] vol_q [MAX_CUBOIDS];
	logic [CW:0]   row_q [MAX_CUBOIDS];
	logic [2*CW+1:0] slab_q [MAX_CUBOIDS];
	logic [MAX_CUBOIDS-1:0] en_q;

	logic [2:0]     state_q;
	logic [1:0]     cmd_q;
	logic [CW-1:0]  c_q [3];
	logic [CW-1:0]  e_q [3];
	logic [1:0]     slot_in_q;
	logic [11:0]    entry_q;
	logic [63:0]    v_q;
	logic [SW:0]    s_q;
	logic [SW:0]    n_q;
	logic [AW-1:0]  addr_q;
	logic [PW-1:0]  prod_q;
	logic [PW-1:0]  idx_q;
	logic           bad_q;
	logic [VW:0]    lbase_q;
	logic [63:0]    sq_q;
	logic           rvalid_q;
	crr_pkg::crr_result_t res_q;

	logic [SW-1:0] si;
	logic          hit;
	logic [CW:0]   dx, dy, dz;
	logic [CW:0]   lx, ly, lz;
	logic [PW-1:0] idx_c;
	logic [63:0]   nv;
	logic [64:0]   sum;
	logic [VW:0]   nb;
	logic signed [63:0] sq_c;

	assign si = s_q[SW-1:0];
	assign in_ready = (state_q == S_IDLE) && !rvalid_q;
	assign res_valid = rvalid_q;
	assign res = res_q;
	assign mem_raddr = (state_q == S_IDLE) ? AW'(entry)
		: (state_q == S_RD) ? AW'(idx_q + prod_q) : addr_q;
	assign mem_we = (state_q == S_WB) || ((state_q == S_IDLE) && in_valid && in_ready
		&& (command == crr_pkg::CMD_WRITE) && (32'(entry) < 32'(STORE_DEPTH)));
	assign mem_waddr = (state_q == S_WB) ? addr_q : AW'(entry);
	assign mem_wdata = (state_q == S_WB) ? nv : init_value;

	always_comb begin
		hit = en_q[si];
		for (int k = 0; k < 3; k++) begin
			if (c_q[k] < lo_q[si][k] || c_q[k] > hi_q[si][k]) begin
				hit = 1'b0;
			end
		end
		dx = {1'b0, c_q[0] - lo_q[si][0]};
		dy = {1'b0, c_q[1] - lo_q[si][1]};
		dz = {1'b0, c_q[2] - lo_q[si][2]};
		lx = {1'b0, e_q[0]} - {1'b0, c_q[0]} + 1'b1;
		ly = {1'b0, e_q[1]} - {1'b0, c_q[1]} + 1'b1;
		lz = {1'b0, e_q[2]} - {1'b0, c_q[2]} + 1'b1;
		sq_c = $signed(sample) * $signed(sample);
		idx_c = PW'(base_q[si]) + PW'(dy) * PW'(row_q[si]) + PW'(dx);
		sum = {mem_rdata[63], mem_rdata} + {1'b0, sq_q};
		case (mode)
			crr_pkg::MODE_COPY: nv = v_q;
			crr_pkg::MODE_SQSUM: nv = (sum[64:63] == 2'b01) ? SMAX : sum[63:0];
			crr_pkg::MODE_MAX: nv = ($signed(v_q) > $signed(mem_rdata)) ? v_q : mem_rdata;
			default: nv = ($signed(v_q) < $signed(mem_rdata)) ? v_q : mem_rdata;
		endcase
		nb = lbase_q + {1'b0, prod_q[VW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rvalid_q <= 1'b0;
			en_q <= '0;
			for (int i = 0; i < MAX_CUBOIDS; i++) begin
				base_q[i] <= '0;
				vol_q[i] <= '0;
				row_q[i] <= '0;
				slab_q[i] <= '0;
				for (int k = 0; k < 3; k++) begin
					lo_q[i][k] <= '0;
					hi_q[i][k] <= '0;
				end
			end
		end else begin
			if (rvalid_q && res_take) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= command;
						c_q[0] <= x[CW-1:0];
						c_q[1] <= y[CW-1:0];
						c_q[2] <= z[CW-1:0];
						e_q[0] <= x_end[CW-1:0];
						e_q[1] <= y_end[CW-1:0];
						e_q[2] <= z_end[CW-1:0];
						slot_in_q <= cuboid;
						entry_q <= entry;
						addr_q <= AW'(entry);
						v_q <= {{32{sample[31]}}, sample};
						sq_q <= sq_c;
						s_q <= '0;
						n_q <= (32'(count) > 32'(MAX_CUBOIDS)) ? (SW+1)'(MAX_CUBOIDS)
							: (SW+1)'(count);
						unique case (command)
							crr_pkg::CMD_SAMPLE: state_q <= S_SCAN;
							crr_pkg::CMD_LOAD: state_q <= S_LD1;
							crr_pkg::CMD_WRITE: state_q <= S_IDLE;
							default: state_q <= S_RDO;
						endcase
					end
				end
				S_SCAN: begin
					if (s_q >= n_q) begin
						state_q <= S_IDLE;
					end else if (hit) begin
						idx_q <= idx_c;
						prod_q <= PW'(dz) * PW'(slab_q[si]);
						state_q <= S_RD;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				S_RD: begin
					if (idx_q + prod_q < PW'(STORE_DEPTH)) begin
						addr_q <= AW'(idx_q + prod_q);
						state_q <= S_WB;
					end else begin
						s_q <= s_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_WB: begin
					s_q <= s_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_LD1: begin
					bad_q <= (e_q[0] < c_q[0]) || (e_q[1] < c_q[1]) || (e_q[2] < c_q[2]);
					idx_q <= PW'(lx) * PW'(ly);
					if (slot_in_q == '0 || 32'(slot_in_q) >= 32'(MAX_CUBOIDS)) begin
						lbase_q <= '0;
					end else begin
						lbase_q <= {1'b0, base_q[SW'(slot_in_q - 1'b1)]}
							+ {1'b0, vol_q[SW'(slot_in_q - 1'b1)]};
					end
					state_q <= S_LD2;
				end
				S_LD2: begin
					prod_q <= idx_q * PW'(lz);
					state_q <= S_RDO;
				end
				default: begin
					state_q <= S_IDLE;
					rvalid_q <= 1'b1;
					res_q.valid <= 1'b1;
					if (cmd_q == crr_pkg::CMD_READ) begin
						res_q.echo <= entry_q;
						if (32'(entry_q) < 32'(STORE_DEPTH)) begin
							res_q.value <= mem_rdata;
							res_q.status <= crr_pkg::ST_OK;
						end else begin
							res_q.value <= '0;
							res_q.status <= crr_pkg::ST_BAD_ADDR;
						end
					end else begin
						res_q.value <= '0;
						if (32'(slot_in_q) >= 32'(MAX_CUBOIDS)) begin
							res_q.echo <= '0;
							res_q.status <= crr_pkg::ST_REJECT;
						end else begin
							res_q.echo <= 12'(nb > (VW+1)'(STORE_DEPTH) || bad_q
								? ((lbase_q > (VW+1)'(STORE_DEPTH))
									? (VW+1)'(STORE_DEPTH) : lbase_q)
								: lbase_q);
							base_q[SW'(slot_in_q)] <= (lbase_q > (VW+1)'(STORE_DEPTH))
								? VW'(STORE_DEPTH) : VW'(lbase_q);
							if (bad_q || (PW'(lbase_q) + prod_q > PW'(STORE_DEPTH))) begin
								res_q.status <= crr_pkg::ST_REJECT;
								en_q[SW'(slot_in_q)] <= 1'b0;
								vol_q[SW'(slot_in_q)] <= '0;
								row_q[SW'(slot_in_q)] <= '0;
								slab_q[SW'(slot_in_q)] <= '0;
								for (int k = 0; k < 3; k++) begin
									lo_q[SW'(slot_in_q)][k] <= '0;
									hi_q[SW'(slot_in_q)][k] <= '0;
								end
							end else begin
								res_q.status <= crr_pkg::ST_OK;
								en_q[SW'(slot_in_q)] <= 1'b1;
								vol_q[SW'(slot_in_q)] <= VW'(prod_q);
								row_q[SW'(slot_in_q)] <= lx;
								slab_q[SW'(slot_in_q)] <= (2*CW+2)'(idx_q);
								for (int k = 0; k < 3; k++) begin
									lo_q[SW'(slot_in_q)][k] <= c_q[k];
									hi_q[SW'(slot_in_q)][k] <= e_q[k];
								end
							end
						end
					end
				end
			endcase
		end
	end
endmodule

### design/cuboid_region_reduction_core.sv
`timescale 1ns / 1ps
// channel   dir  transfer when
// cfg       in   cfg_valid & cfg_ready
// s_axis    in   s_axis_tvalid & s_axis_tready
// m_axis    out  m_axis_tvalid & m_axis_tready
// Sample: accept, a scan step per cuboid checked, a store read and write back per
// in-range hit, and a final scan step. Load: accept, LD1, LD2, result. Read: accept,
// result. Write completes at accept. The store read-modify-write per hit sets the pace.
// arst_n clears the cuboid table, mode/count registers and state; the store is not cleared.
// A waiting result stalls further input until taken.
module cuboid_region_reduction_core #(
	parameter int MAX_CUBOIDS = crr_pkg::MAX_CUBOIDS_DEF,
	parameter int STORE_DEPTH = crr_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS = crr_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [2:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command, x, y, z, x_end, y_end, z_end, cuboid, entry, sample, init_value, pad
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_value, entry_echo, status, pad
	output logic [79:0]  m_axis_tdata
);
	localparam int AW = $clog2(STORE_DEPTH);
	logic [1:0] mode_q;
	logic [2:0] count_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata, rdata;
	crr_pkg::crr_result_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= crr_pkg::MODE_COPY;
			count_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == crr_pkg::REG_MODE) mode_q <= cfg_data[1:0];
			else count_q <= cfg_data;
		end
	end

	crr_ctrl #(.MAX_CUBOIDS(MAX_CUBOIDS), .STORE_DEPTH(STORE_DEPTH),
		.COORD_BITS(COORD_BITS), .AW(AW)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tdata[1:0]), .x(s_axis_tdata[11:2]), .y(s_axis_tdata[21:12]),
		.z(s_axis_tdata[31:22]), .x_end(s_axis_tdata[41:32]),
		.y_end(s_axis_tdata[51:42]), .z_end(s_axis_tdata[61:52]),
		.cuboid(s_axis_tdata[63:62]), .entry(s_axis_tdata[75:64]),
		.sample(s_axis_tdata[107:76]), .init_value(s_axis_tdata[171:108]),
		.mode(mode_q), .count(count_q),
		.res_valid(m_axis_tvalid), .res_take(m_axis_tready), .res(res),
		.mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
		.mem_raddr(raddr), .mem_rdata(rdata)
	);

	crr_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign m_axis_tdata = {2'b00, res.status, res.echo, res.value};
endmodule

### verif/cuboid_region_reduction_core_tb.sv
`timescale 1ns / 1ps
module cuboid_region_reduction_core_tb;
	import crr_pkg::*;

	localparam int NSLOT = 4;
	localparam int DEPTH = 4096;
	localparam longint SQ_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0] cmd;
		logic [9:0] x, y, z, xe, ye, ze;
		logic [1:0] slot;
		logic [11:0] entry;
		logic [31:0] smp;
		logic [63:0] init;
	} cmd_t;

	typedef struct {
		logic [63:0] value;
		logic [11:0] echo;
		logic [1:0] status;
	} reply_t;

	typedef int addr_q_t[$];

	class region_scoreboard;
		logic [1:0] mode;
		logic [2:0] count;
		logic [9:0] lo[NSLOT][3];
		logic [9:0] hi[NSLOT][3];
		int base[NSLOT];
		int row[NSLOT];
		int slab[NSLOT];
		bit en[NSLOT];
		longint store[DEPTH];
		bit written[DEPTH];
		int written_list[$];
		reply_t replies[$];
		int errors;

		function new();
			mode = MODE_COPY;
			count = 0;
			errors = 0;
			for (int s = 0; s < NSLOT; s++) begin
				base[s] = 0;
				row[s] = 0;
				slab[s] = 0;
				en[s] = 0;
				for (int k = 0; k < 3; k++) begin
					lo[s][k] = 0;
					hi[s][k] = 0;
				end
			end
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		endtask

		function void mark(int a);
			if (!written[a]) begin
				written[a] = 1;
				written_list = {written_list, a};
			end
		endfunction

		function int volume(int s);
			if (!en[s])
				return 0;
			return slab[s] * (int'(hi[s][2]) - int'(lo[s][2]) + 1);
		endfunction

		function addr_q_t hit_addrs(logic [9:0] x, logic [9:0] y, logic [9:0] z);
			addr_q_t q;
			logic [9:0] p[3];
			int n;
			int idx;
			bit inr;
			p[0] = x;
			p[1] = y;
			p[2] = z;
			n = (int'(count) > NSLOT) ? NSLOT : int'(count);
			for (int s = 0; s < n; s++) begin
				inr = en[s];
				for (int k = 0; k < 3; k++)
					if (p[k] < lo[s][k] || p[k] > hi[s][k])
						inr = 0;
				if (inr) begin
					idx = base[s] + (int'(z) - int'(lo[s][2])) * slab[s]
						+ (int'(y) - int'(lo[s][1])) * row[s] + (int'(x) - int'(lo[s][0]));
					if (idx < DEPTH)
						q = {q, idx};
				end
			end
			return q;
		endfunction

		function void note_input(cmd_t c);
			addr_q_t q;
			longint v;
			longint sq;
			longint cur;
			int s;
			int b;
			int vol;
			bit bad;
			reply_t r;
			case (c.cmd)
				CMD_SAMPLE: begin
					v = longint'(signed'(c.smp));
					q = hit_addrs(c.x, c.y, c.z);
					foreach (q[i]) begin
						cur = store[q[i]];
						case (mode)
							MODE_COPY: store[q[i]] = v;
							MODE_SQSUM: begin
								sq = v * v;
								store[q[i]] = (cur > SQ_MAX - sq) ? SQ_MAX : cur + sq;
							end
							MODE_MAX: if (v > cur) store[q[i]] = v;
							default: if (v < cur) store[q[i]] = v;
						endcase
						mark(q[i]);
					end
				end
				CMD_LOAD: begin
					s = int'(c.slot);
					b = (s == 0) ? 0 : base[s-1] + volume(s-1);
					bad = (c.xe < c.x) || (c.ye < c.y) || (c.ze < c.z);
					vol = 0;
					if (!bad) begin
						vol = (int'(c.xe) - int'(c.x) + 1) * (int'(c.ye) - int'(c.y) + 1)
							* (int'(c.ze) - int'(c.z) + 1);
						if (b + vol > DEPTH)
							bad = 1;
					end
					if (b > DEPTH)
						b = DEPTH;
					base[s] = b;
					en[s] = !bad;
					lo[s][0] = bad ? 10'd0 : c.x;
					lo[s][1] = bad ? 10'd0 : c.y;
					lo[s][2] = bad ? 10'd0 : c.z;
					hi[s][0] = bad ? 10'd0 : c.xe;
					hi[s][1] = bad ? 10'd0 : c.ye;
					hi[s][2] = bad ? 10'd0 : c.ze;
					row[s] = bad ? 0 : int'(c.xe) - int'(c.x) + 1;
					slab[s] = bad ? 0 : row[s] * (int'(c.ye) - int'(c.y) + 1);
					r.value = '0;
					r.echo = b[11:0];
					r.status = bad ? ST_REJECT : ST_OK;
					replies = {replies, r};
				end
				CMD_WRITE: begin
					store[c.entry] = longint'(c.init);
					mark(int'(c.entry));
				end
				default: begin
					r.value = store[c.entry];
					r.echo = c.entry;
					r.status = ST_OK;
					replies = {replies, r};
				end
			endcase
		endfunction

		task check_result(logic [79:0] d);
			reply_t r;
			if (replies.size() == 0) begin
				report("unexpected transfer", d[63:0], '0);
			end else begin
				r = replies.pop_front();
				if (d[63:0] !== r.value)
					report("read_value", d[63:0], r.value);
				if (d[75:64] !== r.echo)
					report("entry_echo", 64'(d[75:64]), 64'(r.echo));
				if (d[77:76] !== r.status)
					report("status", 64'(d[77:76]), 64'(r.status));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [2:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [79:0] m_axis_tdata;

	region_scoreboard sb;
	bit no_idle;

	cuboid_region_reduction_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		n = $urandom_range(0, 16);
		forever begin
			repeat (n) @(posedge clk);
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			n = no_idle ? 0 : $urandom_range(0, 16);
			if (n > 0)
				m_axis_tready <= 0;
		end
	end

	task send(cmd_t c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {4'd0, c.init, c.smp, c.entry, c.slot, c.ze, c.ye, c.xe,
			c.z, c.y, c.x, c.cmd};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(c);
	endtask

	task wait_idle();
		s_axis_tvalid <= 0;
		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_regs(logic [1:0] mode, logic [2:0] count);
		cfg_valid <= 1;
		cfg_index <= REG_MODE;
		cfg_data <= {1'b0, mode};
		do @(posedge clk); while (!cfg_ready);
		sb.mode = mode;
		cfg_index <= REG_COUNT;
		cfg_data <= count;
		do @(posedge clk); while (!cfg_ready);
		sb.count = count;
		cfg_valid <= 0;
	endtask

	function cmd_t noise();
		cmd_t c;
		c.cmd = CMD_SAMPLE;
		c.x = 10'($urandom);
		c.y = 10'($urandom);
		c.z = 10'($urandom);
		c.xe = 10'($urandom);
		c.ye = 10'($urandom);
		c.ze = 10'($urandom);
		c.slot = 2'($urandom);
		c.entry = 12'($urandom);
		c.smp = $urandom;
		c.init = {$urandom, $urandom};
		return c;
	endfunction

	task load(logic [1:0] s, int x, int y, int z, int xe, int ye, int ze);
		cmd_t c;
		c = noise();
		c.cmd = CMD_LOAD;
		c.slot = s;
		{c.x, c.y, c.z, c.xe, c.ye, c.ze} = {x[9:0], y[9:0], z[9:0], xe[9:0], ye[9:0], ze[9:0]};
		send(c);
	endtask

	task write_entry(int a, logic [63:0] v);
		cmd_t c;
		c = noise();
		c.cmd = CMD_WRITE;
		c.entry = 12'(a);
		c.init = v;
		send(c);
	endtask

	task read_entry(int a);
		cmd_t c;
		if (!sb.written[a]) begin
			if (sb.written_list.size() == 0)
				write_entry(a, {$urandom, $urandom});
			else
				a = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
		end
		c = noise();
		c.cmd = CMD_READ;
		c.entry = 12'(a);
		send(c);
	endtask

	// accumulating modes read the entry first, so seed unwritten hits
	task sample(int x, int y, int z, logic [31:0] v);
		cmd_t c;
		addr_q_t q;
		c = noise();
		c.x = 10'(x);
		c.y = 10'(y);
		c.z = 10'(z);
		c.smp = v;
		if (sb.mode != MODE_COPY) begin
			q = sb.hit_addrs(c.x, c.y, c.z);
			foreach (q[i])
				if (!sb.written[q[i]])
					write_entry(q[i], {{32{1'b0}}, $urandom} - 64'h8000_0000);
		end
		send(c);
	endtask

	function logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	task load_boxes();
		int x, y, z, dx, dy, dz, w;
		for (int s = 0; s < NSLOT; s++) begin
			w = $urandom_range(0, 9);
			dx = $urandom_range(0, 7);
			dy = $urandom_range(0, 7);
			dz = $urandom_range(0, 7);
			if (w == 0) begin
				dx = $urandom_range(100, 1023);
				dy = $urandom_range(100, 1023);
			end
			x = (w < 6) ? $urandom_range(0, 12) : $urandom_range(0, 1023 - dx);
			y = (w < 6) ? $urandom_range(0, 12) : $urandom_range(0, 1023 - dy);
			z = (w < 6) ? $urandom_range(0, 12) : $urandom_range(0, 1023 - dz);
			if (w == 1)
				load(2'(s), x + dx + 1, y, z, x, y + dy, z + dz);
			else if (w == 2)
				load(2'(s), x, y, z + dz + 1, x + dx, y + dy, z);
			else
				load(2'(s), x, y, z, x + dx, y + dy, z + dz);
		end
	endtask

	task random_item();
		int s, w;
		w = $urandom_range(0, 19);
		s = $urandom_range(0, NSLOT - 1);
		if (w < 12 && sb.en[s]) begin
			sample($urandom_range(sb.lo[s][0], sb.hi[s][0]),
				$urandom_range(sb.lo[s][1], sb.hi[s][1]),
				$urandom_range(sb.lo[s][2], sb.hi[s][2]), rand_sample());
		end else if (w < 15) begin
			read_entry(sb.written_list.size() ? 
				sb.written_list[$urandom_range(0, sb.written_list.size() - 1)] : 0);
		end else if (w < 17) begin
			write_entry($urandom_range(0, DEPTH - 1), {$urandom, $urandom});
		end else if (w < 18) begin
			sample($urandom, $urandom, $urandom, rand_sample());
		end else begin
			s = $urandom_range(0, NSLOT - 1);
			load(2'(s), $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
				$urandom_range(0, 25), $urandom_range(0, 25), $urandom_range(0, 25));
		end
	endtask

	initial begin
		logic [1:0] modes[9];
		logic [2:0] counts[9];
		modes = '{MODE_SQSUM, MODE_MAX, MODE_MIN, MODE_COPY, MODE_SQSUM, MODE_MAX,
			MODE_MIN, MODE_COPY, MODE_MAX};
		counts = '{4, 3, 7, 0, 2, 4, 1, 5, 4};
		sb = new();
		no_idle = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = REG_MODE;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_regs(MODE_COPY, 4);
		load(0, 0, 0, 0, 1, 1, 1);
		load(1, 5, 0, 0, 4, 0, 0);
		load(2, 1023, 1023, 1023, 1023, 1023, 1023);
		load(3, 0, 0, 0, 1023, 1023, 0);
		sample(0, 0, 0, 32'h7FFF_FFFF);
		sample(1023, 1023, 1023, 32'h8000_0000);
		sample(1, 1, 1, 32'hFFFF_FFFF);
		read_entry(0);
		read_entry(8);
		read_entry(7);
		write_entry(4095, 64'h7FFF_FFFF_FFFF_FFFF);
		write_entry(4094, 64'h8000_0000_0000_0000);
		read_entry(4095);
		read_entry(4094);
		wait_idle();
		write_regs(MODE_SQSUM, 4);
		write_entry(7, 64'h7FFF_FFFF_FFFF_FFF0);
		sample(1, 1, 1, 32'h8000_0000);
		sample(0, 0, 0, 32'h0001_0000);
		read_entry(7);
		read_entry(0);

		for (int p = 0; p < 9; p++) begin
			wait_idle();
			write_regs(modes[p], counts[p]);
			no_idle = (p % 3 == 2);
			if (p % 2 == 0)
				load_boxes();
			for (int i = 0; i < 36; i++)
				random_item();
		end
		no_idle = 0;
		wait_idle();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### files.f
design/crr_pkg.sv
design/crr_store.sv
design/crr_ctrl.sv
design/cuboid_region_reduction_core.sv
verif/cuboid_region_reduction_core_tb.sv
